/* src/qecp_pkg.sv */
// Shared widths and fixed-point constants for the quadrature edge counter.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package qecp_pkg;

  localparam int unsigned IDX_W  = 2;   // motor index field
  localparam int unsigned CNT_W  = 32;  // wrapping edge count
  localparam int unsigned TS_W   = 32;  // timestamp and period
  localparam int unsigned FRAC_W = 16;  // fraction bits of the revolution output
  localparam int unsigned REV_W  = 48;  // Q16 revolution output
  localparam int unsigned CPR_W  = 16;  // counts per revolution fits this width

  // Per-item fields that ride along the division pipeline.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             up;
    logic [TS_W-1:0]  per;
    logic             neg;
  } qecp_meta_t;

endpackage

/* src/quadrature_edge_counter_period.sv */
// Quadrature x4 edge counter with per-motor edge period and Q16 revolutions.
// Depends on qecp_pkg for field widths and the pipeline side-band struct.
`timescale 1ns / 1ps

// Usage:
//   Each input request is one encoder edge: the motor index, which channel
//   edged, both channel levels and a timestamp. Each request yields exactly
//   one result: the motor's updated count, the direction, the ticks since the
//   motor's previous edge and the count in revolutions (signed Q16).
//   Both channels use valid/ready. A request is accepted on a clock edge with
//   in_valid and in_ready high; a result is taken with out_valid and out_ready.
//   The pipeline takes one request every cycle while the output is not
//   stalled; per-motor state is updated in the first stage after the input
//   register, so back-to-back edges of one motor see each other.
//   The revolution value is formed by two reciprocal multiplications, which
//   set the pipeline depth.
//   When the receiver holds out_ready low with a result pending, the whole
//   pipeline freezes and in_ready drops in the same cycle.
//   Reset (rst_n low, synchronous) empties the pipeline and clears all counts
//   and last edge times to zero. A motor index at or beyond MOTORS changes no
//   state and returns all-zero fields.
module quadrature_edge_counter_period
  import qecp_pkg::*;
#(
  parameter int unsigned MOTORS         = 3,
  parameter int unsigned COUNTS_PER_REV = 2048
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [IDX_W-1:0]        in_motor_index,
  input  logic                    in_edge_on_a,
  input  logic                    in_level_b,
  input  logic                    in_level_a,
  input  logic [TS_W-1:0]         in_timestamp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CNT_W-1:0] out_position_count,
  output logic                    out_direction,
  output logic [TS_W-1:0]         out_edge_period,
  output logic signed [REV_W-1:0] out_revolutions_q16
);

  // Exact division of a 32-bit value by COUNTS_PER_REV: multiply by
  // ceil(2^SH / C) and keep the bits above SH.
  localparam int unsigned SH          = CNT_W + $clog2(COUNTS_PER_REV);
  localparam logic [63:0] RECIP_FULL  =
      ((64'd1 << SH) + 64'(COUNTS_PER_REV) - 64'd1) / 64'(COUNTS_PER_REV);
  localparam logic [CNT_W:0]   RECIP  = RECIP_FULL[CNT_W:0];
  localparam logic [CPR_W-1:0] CPR_V  = CPR_W'(COUNTS_PER_REV);
  localparam int unsigned PW          = 2 * CNT_W + 1;

  logic en;
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  // Stage 0: input register.
  logic [IDX_W-1:0] idx0_r;
  logic             on_a0_r, lb0_r, la0_r;
  logic [TS_W-1:0]  ts0_r;

  // Per-motor state.
  logic [CNT_W-1:0] cnt_r  [MOTORS];
  logic [TS_W-1:0]  time_r [MOTORS];

  logic             ok0;
  logic             up0;
  logic [CNT_W-1:0] old_cnt;
  logic [TS_W-1:0]  old_time;
  logic [CNT_W-1:0] new_cnt;

  qecp_meta_t       m1_nxt, m1_r, m2_r, m3_r, m4_r, m5_r, m6_r;
  logic [CNT_W-1:0] mag2_nxt, mag2_r, mag3_r, mag4_r;
  logic [PW-1:0]    p1_nxt, p1_3_r;
  logic [CNT_W-1:0] qa4_nxt, qa4_r, qa5_r, qa6_r;
  logic [CNT_W-1:0] prod4_nxt, prod4_r;
  logic [CNT_W-1:0] diff5;
  logic [FRAC_W-1:0] ra5_nxt, ra5_r;
  logic [PW-1:0]    p2_nxt, p2_6_r;
  logic [REV_W-1:0] q_mag, revs_nxt, revs_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1 logic: select the motor, step its count, measure the period.
  assign ok0 = (32'(idx0_r) < MOTORS);
  assign up0 = lb0_r ^ la0_r ^ on_a0_r;

  always_comb begin
    old_cnt  = '0;
    old_time = '0;
    for (int k = 0; k < MOTORS; k++) begin
      if (32'(idx0_r) == k) begin
        old_cnt  = cnt_r[k];
        old_time = time_r[k];
      end
    end
  end

  assign new_cnt = up0 ? old_cnt + 1'b1 : old_cnt - 1'b1;

  always_comb begin
    m1_nxt = '0;
    if (ok0) begin
      m1_nxt.cnt = new_cnt;
      m1_nxt.up  = up0;
      m1_nxt.per = ts0_r - old_time;
    end
    m1_nxt.neg = m1_nxt.cnt[CNT_W-1];
  end

  for (genvar g = 0; g < MOTORS; g++) begin : g_motor
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[g]  <= '0;
        time_r[g] <= '0;
      end else if (en && v0_r && ok0 && (32'(idx0_r) == g)) begin
        cnt_r[g]  <= new_cnt;
        time_r[g] <= ts0_r;
      end
    end
  end

  // Division pipeline on the count magnitude; the sign is restored at the end.
  assign mag2_nxt  = m1_r.neg ? (~m1_r.cnt + 1'b1) : m1_r.cnt;
  assign p1_nxt    = {{(CNT_W+1){1'b0}}, mag2_r} * {{CNT_W{1'b0}}, RECIP};
  assign qa4_nxt   = CNT_W'(p1_3_r >> SH);
  assign prod4_nxt = qa4_nxt * {{(CNT_W-CPR_W){1'b0}}, CPR_V};
  assign diff5     = mag4_r - prod4_r;
  assign ra5_nxt   = diff5[FRAC_W-1:0];
  // The remainder is below the divisor, so its scaled quotient fits 16 bits.
  assign p2_nxt    = {{(CNT_W+1){1'b0}}, ra5_r, {FRAC_W{1'b0}}} *
                     {{CNT_W{1'b0}}, RECIP};
  assign q_mag     = {qa6_r, FRAC_W'(p2_6_r >> SH)};
  assign revs_nxt  = m6_r.neg ? (~q_mag + 1'b1) : q_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0_r  <= in_motor_index;
      on_a0_r <= in_edge_on_a;
      lb0_r   <= in_level_b;
      la0_r   <= in_level_a;
      ts0_r   <= in_timestamp;
      m1_r    <= m1_nxt;
      m2_r    <= m1_r;
      mag2_r  <= mag2_nxt;
      m3_r    <= m2_r;
      mag3_r  <= mag2_r;
      p1_3_r  <= p1_nxt;
      m4_r    <= m3_r;
      mag4_r  <= mag3_r;
      qa4_r   <= qa4_nxt;
      prod4_r <= prod4_nxt;
      m5_r    <= m4_r;
      qa5_r   <= qa4_r;
      ra5_r   <= ra5_nxt;
      m6_r    <= m5_r;
      qa6_r   <= qa5_r;
      p2_6_r  <= p2_nxt;
      revs_r  <= revs_nxt;
    end
  end

  // Output register: count, direction and period come with the last stage.
  logic [CNT_W-1:0] pos_r;
  logic             dir_r;
  logic [TS_W-1:0]  per_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= m6_r.cnt;
      dir_r <= m6_r.up;
      per_r <= m6_r.per;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_position_count  = $signed(pos_r);
  assign out_direction       = dir_r;
  assign out_edge_period     = per_r;
  assign out_revolutions_q16 = $signed(revs_r);

endmodule

/* src/qecp_chk.sv */
// Port-level checker for the quadrature edge counter, bound to the top level.
// Depends on qecp_pkg for field widths.
`timescale 1ns / 1ps

module qecp_chk
  import qecp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [IDX_W-1:0]        in_motor_index,
  input logic                    in_edge_on_a,
  input logic                    in_level_b,
  input logic                    in_level_a,
  input logic [TS_W-1:0]         in_timestamp,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [CNT_W-1:0] out_position_count,
  input logic                    out_direction,
  input logic [TS_W-1:0]         out_edge_period,
  input logic signed [REV_W-1:0] out_revolutions_q16
);

  // A waiting request keeps its fields until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_motor_index) &&
      $stable(in_edge_on_a) && $stable(in_level_b) && $stable(in_level_a) &&
      $stable(in_timestamp))
    else $error("request changed while waiting");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position_count) &&
      $stable(out_direction) && $stable(out_edge_period) &&
      $stable(out_revolutions_q16))
    else $error("result changed while stalled");

  // A stalled output freezes the pipeline, so no new request may enter.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // Revolutions carry the sign of the count and are zero only with it.
  a_rev_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_revolutions_q16[REV_W-1] == out_position_count[CNT_W-1]) &&
      ((out_revolutions_q16 == '0) == (out_position_count == '0)))
    else $error("revolutions disagree with count sign");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

endmodule

bind quadrature_edge_counter_period qecp_chk u_qecp_chk (.*);

/* test/qecp_result_checker.sv */
// Result checker for the quadrature edge counter: it predicts each request's result and
// compares the block's results against those predictions in order.
// Depends on qecp_pkg for the field widths.
`timescale 1ns / 1ps

module qecp_result_checker
  import qecp_pkg::*;
#(
  parameter int unsigned MOTORS         = 3,
  parameter int unsigned COUNTS_PER_REV = 2048
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [IDX_W-1:0]        in_motor_index,
  input  logic                    in_edge_on_a,
  input  logic                    in_level_b,
  input  logic                    in_level_a,
  input  logic [TS_W-1:0]         in_timestamp,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [CNT_W-1:0] out_position_count,
  input  logic                    out_direction,
  input  logic [TS_W-1:0]         out_edge_period,
  input  logic signed [REV_W-1:0] out_revolutions_q16,
  output int                      mismatches,
  output int                      reports_due
);

  typedef struct packed {
    logic [CNT_W-1:0] position;
    logic             up;
    logic [TS_W-1:0]  period;
    logic [REV_W-1:0] revs;
  } edge_report_t;

  localparam longint CPR = longint'(COUNTS_PER_REV);

  logic [CNT_W-1:0] motor_count   [MOTORS];
  logic [TS_W-1:0]  motor_last_ts [MOTORS];
  edge_report_t     edge_reports_due [$];

  // Applies one edge to the tracked motor state and returns the result it must produce.
  function automatic edge_report_t decode_edge(input logic [IDX_W-1:0] idx,
                                               input logic on_a, lb, la,
                                               input logic [TS_W-1:0] ts);
    edge_report_t             r;
    logic signed [CNT_W-1:0]  pos;
    longint                   scaled;
    r = '0;
    if (idx < MOTORS) begin
      r.up = lb ^ la ^ on_a;
      motor_count[idx] = r.up ? motor_count[idx] + 32'd1 : motor_count[idx] - 32'd1;
      pos = motor_count[idx];
      r.position = pos;
      r.period = ts - motor_last_ts[idx];
      motor_last_ts[idx] = ts;
      // SystemVerilog division truncates toward zero, as the block must.
      scaled = (longint'(pos) * 65536) / CPR;
      r.revs = scaled[REV_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    edge_report_t want;
    if (!rst_n) begin
      for (int k = 0; k < MOTORS; k++) begin
        motor_count[k]   = '0;
        motor_last_ts[k] = '0;
      end
      edge_reports_due.delete();
      reports_due = 0;
    end else begin
      // Results pass through the pipeline registers, so a result never belongs to a request
      // accepted on the same edge.
      if (out_valid && out_ready) begin
        if (edge_reports_due.size() == 0) begin
          $error("result with position %0d arrived with no request outstanding",
                 out_position_count);
          mismatches++;
        end else begin
          want = edge_reports_due.pop_front();
          check_field("position_count", signed'(want.position), out_position_count);
          check_field("direction", want.up, out_direction);
          check_field("edge_period", want.period, out_edge_period);
          check_field("revolutions_q16", signed'(want.revs), out_revolutions_q16);
        end
      end
      if (in_valid && in_ready) begin
        edge_reports_due.push_back(decode_edge(in_motor_index, in_edge_on_a, in_level_b,
                                               in_level_a, in_timestamp));
      end
      reports_due = edge_reports_due.size();
    end
  end

endmodule

/* test/tb_top.sv */
// Top of the quadrature edge counter testbench: clock, reset, request and result traffic.
// Depends on qecp_pkg, the block under test and qecp_result_checker.
`timescale 1ns / 1ps

module tb_top
  import qecp_pkg::*;
();

  localparam int unsigned MOTORS         = 3;
  localparam int unsigned COUNTS_PER_REV = 2048;
  localparam int          RANDOM_EDGES   = 750;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [IDX_W-1:0]        in_motor_index;
  logic                    in_edge_on_a;
  logic                    in_level_b;
  logic                    in_level_a;
  logic [TS_W-1:0]         in_timestamp;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [CNT_W-1:0] out_position_count;
  logic                    out_direction;
  logic [TS_W-1:0]         out_edge_period;
  logic signed [REV_W-1:0] out_revolutions_q16;
  int                      mismatches;
  int                      reports_due;
  logic                    quiet;
  logic                    rx_stalls;

  quadrature_edge_counter_period #(
    .MOTORS(MOTORS),
    .COUNTS_PER_REV(COUNTS_PER_REV)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_motor_index(in_motor_index),
    .in_edge_on_a(in_edge_on_a),
    .in_level_b(in_level_b),
    .in_level_a(in_level_a),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_position_count(out_position_count),
    .out_direction(out_direction),
    .out_edge_period(out_edge_period),
    .out_revolutions_q16(out_revolutions_q16)
  );

  qecp_result_checker #(
    .MOTORS(MOTORS),
    .COUNTS_PER_REV(COUNTS_PER_REV)
  ) result_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_motor_index(in_motor_index),
    .in_edge_on_a(in_edge_on_a),
    .in_level_b(in_level_b),
    .in_level_a(in_level_a),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_position_count(out_position_count),
    .out_direction(out_direction),
    .out_edge_period(out_edge_period),
    .out_revolutions_q16(out_revolutions_q16),
    .mismatches(mismatches),
    .reports_due(reports_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: ready for a random stretch, then now and then a stall burst.
  initial begin : receiver
    int stretch;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      stretch = $urandom_range(1, 40);
      repeat (stretch) @(negedge clk);
      if (!quiet && rx_stalls && $urandom_range(0, 1)) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_edge(input logic [IDX_W-1:0] idx, input logic on_a, lb, la,
                           input logic [TS_W-1:0] ts);
    in_valid       <= 1'b1;
    in_motor_index <= idx;
    in_edge_on_a   <= on_a;
    in_level_b     <= lb;
    in_level_a     <= la;
    in_timestamp   <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid     <= 1'b0;
    in_timestamp <= $urandom;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (reports_due != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int               idle_pct;
    int               up_pct;
    logic             up;
    logic             la;
    logic             lb;
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  tick;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_motor_index = '0;
    in_edge_on_a   = 1'b0;
    in_level_b     = 1'b0;
    in_level_a     = 1'b0;
    in_timestamp   = '0;
    quiet          = 1'b0;
    rx_stalls      = 1'b0;
    idle_pct       = 0;
    up_pct         = 50;
    tick           = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every level combination on motor 0; the first one is its first edge after reset.
    for (int k = 0; k < 8; k++) send_edge(2'd0, k[2], k[1], k[0], 32'd100 * k + 32'd7);
    send_edge(2'd1, 1'b0, 1'b1, 1'b0, '1);
    send_edge(2'd1, 1'b1, 1'b1, 1'b1, 32'd3);          // tick counter wrapped
    send_edge(2'd2, 1'b0, 1'b0, 1'b0, 32'd0);          // first edge at time zero
    send_edge(2'd2, 1'b0, 1'b1, 1'b1, 32'h8000_0000);
    send_edge(2'd2, 1'b1, 1'b0, 1'b1, 32'h8000_0000);  // same tick twice
    send_edge(2'd3, 1'b1, 1'b1, 1'b1, '1);             // motor index out of range
    send_edge(2'd3, 1'b0, 1'b0, 1'b0, 32'd0);
    send_edge(2'd3, 1'b0, 1'b1, 1'b0, 32'h5555_aaaa);
    send_edge(2'd0, 1'b0, 1'b1, 1'b0, 32'd0);
    send_edge(2'd2, 1'b1, 1'b1, 1'b0, 32'haaaa_5555);
    drain_results();

    for (int n = 0; n < RANDOM_EDGES; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 50;
        endcase
        rx_stalls = ($urandom_range(0, 3) != 0);
        // A bias per phase lets the counts drift well away from zero in both signs.
        up_pct = $urandom_range(15, 85);
      end
      if (n >= RANDOM_EDGES - 100) begin
        quiet    = 1'b1;
        idle_pct = 0;
      end
      if (n == 250 || n == 500) drain_results();
      if ($urandom_range(0, 99) < idle_pct) idle_gap($urandom_range(1, 16));

      idx  = ($urandom_range(0, 9) == 0) ? 2'd3 : IDX_W'($urandom_range(0, MOTORS - 1));
      up   = ($urandom_range(0, 99) < up_pct);
      la   = 1'($urandom_range(0, 1));
      lb   = 1'($urandom_range(0, 1));
      tick = tick + $urandom_range(0, 3000);
      if ($urandom_range(0, 19) == 0) tick = $urandom;
      send_edge(idx, up ^ la ^ lb, lb, la, tick);
    end

    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
src/qecp_pkg.sv
src/quadrature_edge_counter_period.sv
src/qecp_chk.sv
test/qecp_result_checker.sv
test/tb_top.sv
